@@ rtl/dqf_pkg.sv @@
// ----------------------------------------------------------------------------
// dqf_pkg
// Shared types, character codes and byte classifiers for the dotted quad
// IPv4 finder.
// ----------------------------------------------------------------------------
package dqf_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [11:0] OCTET_MAX = 12'd255;
	localparam logic [7:0]  LOOPBACK  = 8'd127;
	localparam logic [1:0]  LAST_OCTET = 2'd3;
	localparam logic [1:0]  MAX_DIGITS = 2'd3;

	localparam int OFFSET_W = 16;
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = 56;

	typedef struct packed {
		logic                found;
		logic                done_res;
		logic [OFFSET_W-1:0] start_offset;
		logic [3:0]          match_length;
		logic [31:0]         address;
	} dqf_result_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_dig(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_joiner(input logic [7:0] c);
		return is_alnum(c) || (c == CH_DOT) || (c == CH_UNDER);
	endfunction

endpackage

@@ rtl/dqf_core.sv @@
// ----------------------------------------------------------------------------
// dqf_core
// Per-byte scanner state: candidate tracking, octet accumulation, match
// confirmation and the result it produces on a confirmed match or last byte.
// ----------------------------------------------------------------------------
module dqf_core #(
	parameter int MAX_BYTES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic [7:0]         byte_s1,
	input  logic               last_s1,
	output logic               res_valid,
	output dqf_pkg::dqf_result_t res
);
	import dqf_pkg::*;

	localparam int POS_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BYTES - 1);

	logic [POS_W-1:0] pos_q, pos_n;
	logic             parsing_q, parsing_n;
	logic [1:0]       oi_q, oi_n;
	logic [1:0]       dc_q, dc_n;
	logic [9:0]       ov_q, ov_n;
	logic             fdz_q, fdz_n;
	logic [31:0]      addr_q, addr_n;
	logic [POS_W-1:0] cstart_q, cstart_n;
	logic             pj_q, pj_n;
	logic             found_q, found_n;
	logic [3:0]       tl_q, tl_n;

	logic             dig;
	logic [11:0]      v;
	logic             confirm;
	logic             fail;
	logic [31:0]      full;
	logic [OFFSET_W-1:0] offset;

	assign dig = is_dig(byte_s1);
	assign v = {ov_q[8:0], 3'b000} + {1'b0, ov_q, 1'b0} + {4'd0, byte_s1 - CH_ZERO};

	generate
		if (POS_W >= OFFSET_W) begin : g_off_trunc
			assign offset = cstart_q[OFFSET_W-1:0];
		end else begin : g_off_ext
			assign offset = {{(OFFSET_W-POS_W){1'b0}}, cstart_q};
		end
	endgenerate

	always_comb begin
		pos_n     = pos_q;
		parsing_n = parsing_q;
		oi_n      = oi_q;
		dc_n      = dc_q;
		ov_n      = ov_q;
		fdz_n     = fdz_q;
		addr_n    = addr_q;
		cstart_n  = cstart_q;
		pj_n      = pj_q;
		found_n   = found_q;
		tl_n      = tl_q;
		confirm   = 1'b0;
		fail      = 1'b0;
		full      = '0;
		res_valid = 1'b0;
		res       = '0;

		if (parsing_q) begin
			if (dig) begin
				if ((dc_q == MAX_DIGITS) || ((dc_q != 2'd0) && fdz_q) || (v > OCTET_MAX)) begin
					fail = 1'b1;
				end else begin
					if (dc_q == 2'd0) fdz_n = (byte_s1 == CH_ZERO);
					ov_n = v[9:0];
					dc_n = dc_q + 2'd1;
					tl_n = tl_q + 4'd1;
					if ((oi_q == LAST_OCTET) && last_s1) confirm = 1'b1;
				end
			end else if (byte_s1 == CH_DOT) begin
				if ((dc_q == 2'd0) || (oi_q == LAST_OCTET)) begin
					fail = 1'b1;
				end else begin
					addr_n = {addr_q[23:0], ov_q[7:0]};
					oi_n   = oi_q + 2'd1;
					dc_n   = 2'd0;
					ov_n   = '0;
					fdz_n  = 1'b0;
					tl_n   = tl_q + 4'd1;
				end
			end else if ((oi_q == LAST_OCTET) && (dc_q != 2'd0) && !is_joiner(byte_s1)) begin
				confirm = 1'b1;
			end else begin
				fail = 1'b1;
			end

			if (confirm) begin
				full = {addr_q[23:0], ov_n[7:0]};
				parsing_n = 1'b0;
				if ((full[31:24] == 8'd0) || (full[31:24] == LOOPBACK)) confirm = 1'b0;
			end else if (fail) begin
				parsing_n = 1'b0;
			end
		end

		if (!parsing_n && !confirm && !found_q && dig && !pj_q) begin
			parsing_n = 1'b1;
			cstart_n  = pos_q;
			oi_n      = 2'd0;
			dc_n      = 2'd1;
			ov_n      = {2'b00, byte_s1 - CH_ZERO};
			fdz_n     = (byte_s1 == CH_ZERO);
			addr_n    = '0;
			tl_n      = 4'd1;
		end

		pj_n = is_joiner(byte_s1);

		if (confirm) begin
			found_n          = 1'b1;
			res_valid        = valid_s1;
			res.found        = 1'b1;
			res.done_res     = last_s1;
			res.start_offset = offset;
			res.match_length = tl_n;
			res.address      = full;
		end else if (last_s1) begin
			res_valid    = valid_s1;
			res.found    = found_q;
			res.done_res = 1'b1;
		end

		if (last_s1) begin
			pos_n     = '0;
			parsing_n = 1'b0;
			oi_n      = '0;
			dc_n      = '0;
			ov_n      = '0;
			fdz_n     = 1'b0;
			addr_n    = '0;
			cstart_n  = '0;
			pj_n      = 1'b0;
			found_n   = 1'b0;
			tl_n      = '0;
		end else if (pos_q < POS_MAX) begin
			pos_n = pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			parsing_q <= 1'b0;
			oi_q      <= '0;
			dc_q      <= '0;
			ov_q      <= '0;
			fdz_q     <= 1'b0;
			addr_q    <= '0;
			cstart_q  <= '0;
			pj_q      <= 1'b0;
			found_q   <= 1'b0;
			tl_q      <= '0;
		end else if (valid_s1) begin
			pos_q     <= pos_n;
			parsing_q <= parsing_n;
			oi_q      <= oi_n;
			dc_q      <= dc_n;
			ov_q      <= ov_n;
			fdz_q     <= fdz_n;
			addr_q    <= addr_n;
			cstart_q  <= cstart_n;
			pj_q      <= pj_n;
			found_q   <= found_n;
			tl_q      <= tl_n;
		end
	end

endmodule

@@ rtl/dqf_out_fifo.sv @@
// ----------------------------------------------------------------------------
// dqf_out_fifo
// Two-entry result buffer between the scanner and the master stream side.
// ----------------------------------------------------------------------------
module dqf_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dqf_pkg::dqf_result_t push_data,
	input  logic                 pop,
	output logic                 not_empty,
	output logic [1:0]           level,
	output dqf_pkg::dqf_result_t head
);
	import dqf_pkg::*;

	dqf_result_t mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  level_q;

	assign not_empty = (level_q != 2'd0);
	assign level     = level_q;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

@@ rtl/dotted_quad_ipv4_finder.sv @@
// ----------------------------------------------------------------------------
// dotted_quad_ipv4_finder
// Scans a byte stream buffer by buffer and reports the first IPv4 dotted quad.
//
// Slave side: one byte per transaction in s_tdata[7:0], s_tlast on the final
// byte of a buffer. Master side: at most one result transaction per byte. A
// result comes when a match is confirmed and on the last byte of each buffer;
// m_tlast marks the result that closes the buffer, m_tuser is found.
// Throughput: one byte per cycle while s_tready is high; the scanner updates its state once per byte.
// A byte that is taken goes into the input register, then the scanner pushes
// its result into the two-entry result buffer, from which it is offered.
// Reset clears the scanner state and the result buffer; the next byte starts a
// new buffer at offset 0. When the receiver stalls, results wait in the buffer
// and s_tready drops only once the buffer and the input register could not
// take another result.
// ----------------------------------------------------------------------------
module dotted_quad_ipv4_finder #(
	parameter int MAX_BYTES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dqf_pkg::TDATA_IN_W-1:0]      s_tdata,  // byte_value[7:0]
	input  logic                                s_tlast,  // last_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dqf_pkg::TDATA_OUT_W-1:0]     m_tdata,  // start_offset[15:0],
	                                                      // match_length[19:16],
	                                                      // address[51:20], zero pad
	output logic                                m_tlast,  // done_res
	output logic                                m_tuser   // found
);
	import dqf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        s_accept;
	logic        pop;
	logic        res_valid;
	dqf_result_t res;
	dqf_result_t head;
	logic [1:0]  level;
	logic        not_empty;
	logic [2:0]  pending;

	assign pop      = m_tvalid && m_tready;
	assign pending  = {1'b0, level} + {2'b00, valid_s1} - {2'b00, pop};
	assign s_tready = (pending <= 3'd1);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	dqf_core #(
		.MAX_BYTES(MAX_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	dqf_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.pop      (pop),
		.not_empty(not_empty),
		.level    (level),
		.head     (head)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {4'd0, head.address, head.match_length, head.start_offset};
	assign m_tlast  = head.done_res;
	assign m_tuser  = head.found;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && (level == 2'd2) && !pop))
		else $error("result pushed into a full buffer");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level != 2'd3)
		else $error("result buffer level out of range");

	a_open_result_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> m_tuser)
		else $error("mid-buffer result without a match");

	a_ready_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		((level == 2'd2) && !pop) |-> !s_tready)
		else $error("input taken while result buffer full");

endmodule
